### hdl/assert_macros.svh
// Assertion macros shared by the search unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/fch_pkg.sv
// Shared types, constants and functions of the candidate hash search unit
package fch_pkg;

   localparam int unsigned TBL_DEPTH = 64;
   localparam int unsigned TBL_AW    = 6;
   localparam int unsigned CNT_W     = 7;

   localparam logic [CNT_W-1:0] DICT_SIZE   = 7'd64;
   localparam logic [CNT_W-1:0] SUFFIX_SIZE = 7'd64;
   localparam logic [CNT_W-1:0] TARGET_CNT  = 7'd64;
   localparam logic [CNT_W-1:0] MAX_DIGITS  = 7'd64;
   localparam logic [CNT_W-1:0] MIN_BASE    = 7'd2;

   localparam logic [63:0] FNV_LOW     = 64'h1b3;
   localparam logic [63:0] START_RESET = 64'hcbf29ce484222325;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_UPPA   = 8'h41;
   localparam logic [7:0] CHAR_UPPZ   = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam int unsigned CSR_AW = 5;
   localparam logic [1:0] CSR_START  = 2'd0;
   localparam logic [1:0] CSR_DLEN   = 2'd1;
   localparam logic [1:0] CSR_SLEN   = 2'd2;

   typedef enum logic [1:0] {
      FUNC_DICT   = 2'd0,
      FUNC_SUFFIX = 2'd1,
      FUNC_TARGET = 2'd2,
      FUNC_TEST   = 2'd3
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [TBL_AW-1:0] index;
      logic [63:0]       value;
      logic [63:0]       cand;
   } entry_type;

   function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] c);
      logic [63:0] x;
      logic [63:0] lo;
      x  = h ^ {{56{c[7]}}, c};
      lo = x * FNV_LOW;
      return (x << 40) + lo;
   endfunction

   function automatic logic [7:0] map_suffix(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c == CHAR_BSLASH) begin
         r = CHAR_SLASH;
      end else if (c >= CHAR_UPPA && c <= CHAR_UPPZ) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

### hdl/fch_front.sv
// Request intake: classify requests and queue them for the search engine
`include "assert_macros.svh"
module fch_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [5:0]          req_entry_index,
   input  logic [63:0]         req_entry_value,
   input  logic [63:0]         req_candidate_index,
   output logic                q_valid,
   output fch_pkg::entry_type  q_entry,
   input  logic                q_pop
);
   import fch_pkg::*;

   entry_type   fifo_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;
   entry_type   entry;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = fifo_ff[rd_ptr_ff];

   always_comb begin
      entry.func  = func_type'(req_func);
      entry.index = req_entry_index;
      entry.value = req_entry_value;
      entry.cand  = req_candidate_index;
      if (func_type'(req_func) == FUNC_SUFFIX) begin
         entry.value = {56'd0, map_suffix(req_entry_value[7:0])};
      end
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry;
      end
   end

   `CHK_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)
   `CHK_NEXT(a_pop_drains, clock, reset, pop && !push, count_ff == $past(count_ff) - 2'd1)
   `CHK_NEXT(a_push_fills, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

### hdl/fch_back.sv
// Search engine: table loads, digit split, FNV-1a hashing and target scan
`include "assert_macros.svh"
module fch_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  fch_pkg::entry_type  q_entry,
   output logic                q_pop,
   input  logic [63:0]         start_hash,
   input  logic [6:0]          dict_len,
   input  logic [6:0]          suffix_len,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [62:0]         rsp_hash_value,
   output logic [63:0]         rsp_tested_index
);
   import fch_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_CHECK = 8'b00000010,
      ST_DIV   = 8'b00000100,
      ST_DMIX  = 8'b00001000,
      ST_SREAD = 8'b00010000,
      ST_SMIX  = 8'b00100000,
      ST_SCAN  = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

   state_type          state_ff, state_in;
   logic [63:0]        d_ff, d_in;
   logic [63:0]        h_ff, h_in;
   logic [63:0]        cand_ff, cand_in;
   logic [CNT_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]   slen_ff, slen_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [4:0]         step_ff, step_in;
   logic [CNT_W-1:0]   dig_ff, dig_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   si_ff, si_in;
   logic [CNT_W-1:0]   ti_ff, ti_in;
   logic               pend_ff, pend_in;
   logic [TBL_AW-1:0]  pidx_ff, pidx_in;
   logic               found_ff, found_in;
   logic [TBL_DEPTH-1:0] tvalid_ff;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [62:0]        rsp_hash_ff;
   logic [63:0]        rsp_index_ff;

   logic [7:0]         dict_mem [TBL_DEPTH];
   logic [7:0]         suf_mem  [TBL_DEPTH];
   logic [62:0]        tgt_mem  [TBL_DEPTH];
   logic [7:0]         dict_q_ff;
   logic [7:0]         suf_q_ff;
   logic [62:0]        tgt_q_ff;

   logic [CNT_W-1:0]   r1, r1n, r2, r2n;
   logic               ge1, ge2;
   logic [TBL_AW-1:0]  dict_raddr;
   logic               load_take;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE);
   assign load_take = q_pop && q_valid && (q_entry.func != FUNC_TEST);

   always_comb begin
      r1  = {rem_ff[5:0], d_ff[63]};
      ge1 = (r1 >= base_ff);
      r1n = ge1 ? r1 - base_ff : r1;
      r2  = {r1n[5:0], d_ff[62]};
      ge2 = (r2 >= base_ff);
      r2n = ge2 ? r2 - base_ff : r2;
      dict_raddr = (state_ff == ST_CHECK) ? d_ff[TBL_AW-1:0] : r2n[TBL_AW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      d_in     = d_ff;
      h_in     = h_ff;
      cand_in  = cand_ff;
      base_in  = base_ff;
      slen_in  = slen_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      dig_in   = dig_ff;
      last_in  = last_ff;
      si_in    = si_ff;
      ti_in    = ti_ff;
      pend_in  = 1'b0;
      pidx_in  = pidx_ff;
      found_in = found_ff;
      if (pend_ff && tvalid_ff[pidx_ff] && (tgt_q_ff == h_ff[62:0])) begin
         found_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_entry.func == FUNC_TEST) begin
               d_in    = q_entry.cand;
               cand_in = q_entry.cand;
               h_in    = start_hash;
               dig_in  = '0;
               base_in = (dict_len < MIN_BASE) ? MIN_BASE :
                         (dict_len > DICT_SIZE) ? DICT_SIZE : dict_len;
               slen_in = (suffix_len > SUFFIX_SIZE) ? SUFFIX_SIZE : suffix_len;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (dig_ff == MAX_DIGITS) begin
               si_in    = '0;
               state_in = ST_SREAD;
            end else if (d_ff >= {57'd0, base_ff}) begin
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               last_in  = 1'b1;
               state_in = ST_DMIX;
            end
         end
         ST_DIV: begin
            d_in    = {d_ff[61:0], ge1, ge2};
            rem_in  = r2n;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               d_in     = {d_ff[61:0], ge1, ge2} - 64'd1;
               last_in  = 1'b0;
               state_in = ST_DMIX;
            end
         end
         ST_DMIX: begin
            h_in   = fnv_mix(h_ff, dict_q_ff);
            dig_in = dig_ff + 7'd1;
            if (last_ff) begin
               si_in    = '0;
               state_in = ST_SREAD;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_SREAD: begin
            if (si_ff == slen_ff) begin
               ti_in    = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_SMIX;
            end
         end
         ST_SMIX: begin
            h_in     = fnv_mix(h_ff, suf_q_ff);
            si_in    = si_ff + 7'd1;
            state_in = ST_SREAD;
         end
         ST_SCAN: begin
            if (ti_ff != TARGET_CNT) begin
               ti_in   = ti_ff + 7'd1;
               pend_in = 1'b1;
               pidx_in = ti_ff[TBL_AW-1:0];
            end else if (!pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         tvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (load_take && q_entry.func == FUNC_TARGET) begin
            tvalid_ff[q_entry.index] <= 1'b1;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff     <= d_in;
      h_ff     <= h_in;
      cand_ff  <= cand_in;
      base_ff  <= base_in;
      slen_ff  <= slen_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      dig_ff   <= dig_in;
      last_ff  <= last_in;
      si_ff    <= si_in;
      ti_ff    <= ti_in;
      pidx_ff  <= pidx_in;
      found_ff <= found_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_found_ff <= found_ff;
         rsp_hash_ff  <= h_ff[62:0];
         rsp_index_ff <= cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_take && q_entry.func == FUNC_DICT) begin
         dict_mem[q_entry.index] <= q_entry.value[7:0];
      end
      dict_q_ff <= dict_mem[dict_raddr];
   end

   always_ff @(posedge clock) begin
      if (load_take && q_entry.func == FUNC_SUFFIX) begin
         suf_mem[q_entry.index] <= q_entry.value[7:0];
      end
      suf_q_ff <= suf_mem[si_ff[TBL_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (load_take && q_entry.func == FUNC_TARGET) begin
         tgt_mem[q_entry.index] <= q_entry.value[62:0];
      end
      tgt_q_ff <= tgt_mem[ti_ff[TBL_AW-1:0]];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_hash_value   = rsp_hash_ff;
   assign rsp_tested_index = rsp_index_ff;

   `CHK_IMPLIES(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `CHK_IMPLIES(a_rem_below_base, clock, reset, state_ff == ST_DIV, rem_ff < base_ff)
   `CHK_NEXT(a_result_after_done, clock, reset, state_ff == ST_DONE && out_free, rsp_valid_ff)

endmodule

### hdl/fnv1a_candidate_hash_search_unit.sv
// Top level of the FNV-1a candidate hash search unit with its register port
//
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  func, entry_index, entry_value, candidate_index
// rsp_      out        rsp_valid/rsp_ready  found, hash_value, tested_index
// csr_      in         APB psel/penable     start_hash, dict_len, suffix_len
//
// The engine takes a load request while idle; a two-entry queue sits in front of it.
// A test request hashes D digits of the candidate, then S suffix characters:
// each digit but the last costs a check, a radix-4 divide and one hash step.
// The result sits in an output register; the engine holds in its done state only while
// an earlier result still waits for rsp_ready.
// Reset is synchronous and clears control state and all target valid marks.
module fnv1a_candidate_hash_search_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_entry_index,
   input  logic [63:0] req_entry_value,
   input  logic [63:0] req_candidate_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [62:0] rsp_hash_value,
   output logic [63:0] rsp_tested_index,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import fch_pkg::*;

   logic [63:0] start_ff;
   logic [6:0]  dlen_ff;
   logic [6:0]  slen_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;
   logic        q_valid;
   entry_type   q_entry;
   logic        q_pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         dlen_ff  <= MIN_BASE;
         slen_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_START: start_ff <= csr_pwdata;
            CSR_DLEN:  dlen_ff  <= csr_pwdata[6:0];
            CSR_SLEN:  slen_ff  <= csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_START: csr_prdata = start_ff;
         CSR_DLEN:  csr_prdata = {57'd0, dlen_ff};
         CSR_SLEN:  csr_prdata = {57'd0, slen_ff};
         default:   csr_prdata = '0;
      endcase
   end

   fch_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_entry_index     (req_entry_index),
      .req_entry_value     (req_entry_value),
      .req_candidate_index (req_candidate_index),
      .q_valid             (q_valid),
      .q_entry             (q_entry),
      .q_pop               (q_pop)
   );

   fch_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .start_hash       (start_ff),
      .dict_len         (dlen_ff),
      .suffix_len       (slen_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_tested_index (rsp_tested_index)
   );

endmodule
